>>> rtl/rlbc_pkg.sv
// Shared constants, state encoding and modular arithmetic for the run-limited string counter.
package rlbc_pkg;

    localparam int DATA_W = 30;
    localparam int IN_W = 9;
    localparam int DEF_MAX_COUNT = 256;
    localparam int DEF_MAX_LIMIT = 256;
    localparam logic [DATA_W:0] PRIME = 31'd1000000007;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ADD,
        S_UPD,
        S_RING,
        S_FINISH
    } state_t;

    // Sum of two reduced residues, reduced again.
    function automatic logic [DATA_W-1:0] mod_add(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= PRIME)
        begin
            s = s - PRIME;
        end
        return s[DATA_W-1:0];
    endfunction

    // Difference of two reduced residues, reduced again.
    function automatic logic [DATA_W-1:0] mod_sub(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] d;
        if (a >= b)
        begin
            d = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            d = {1'b0, a} + PRIME - {1'b0, b};
        end
        return d[DATA_W-1:0];
    endfunction

endpackage

>>> rtl/run_limited_binary_count_core.sv
// Top level of the run-limited binary string counter.
//
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-----------------------------------------
// request  | in        | in_valid / in_ready  | zero_count, ones_count, run_limit (9 b)
// result   | out       | out_valid / out_ready| string_count (30 b), bad_request (1 b)
//
// After a valid request is accepted, the core walks all (zero_count + 1) * (ones_count + 1)
// table cells; each cell is a read, add, update and ring step on the dual-port window
// memories, and out_valid rises when the finish step loads the output register.
// A request out of bounds skips the table walk and goes straight to the finish step.
// Reset clears control state and the ring register; no memory needs a clearing pass,
// since each request uses only memory entries that it has written itself.
// A new request is taken as soon as the previous one has been moved into the output
// register, even while that result still waits for out_ready; the finish step stalls
// until the output register is free.
module run_limited_binary_count_core
    import rlbc_pkg::*;
#(
    parameter int MAX_COUNT = DEF_MAX_COUNT,
    parameter int MAX_LIMIT = DEF_MAX_LIMIT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [IN_W-1:0]   zero_count,
    input  logic [IN_W-1:0]   ones_count,
    input  logic [IN_W-1:0]   run_limit,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] string_count,
    output logic              bad_request
);

    localparam int ROW_W = MAX_COUNT + 1;
    localparam int IDX_W = $clog2(ROW_W);
    localparam int LIM_W = $clog2(MAX_LIMIT + 1);
    localparam int HIST_D = ROW_W * ROW_W;
    localparam int HADDR_W = $clog2(HIST_D);

    // Control state.
    state_t state_reg, state_next;
    logic [IDX_W-1:0] zc_reg, oc_reg, row_reg, col_reg;
    logic [LIM_W-1:0] lim_reg;
    logic [HADDR_W-1:0] wr_base_reg, rd_base_reg;
    logic out_valid_reg, bad_reg, bad_out_reg;

    // Datapath registers.
    logic [DATA_W-1:0] ring_reg, sum_reg, r1_reg, cnew_reg, rrv_reg, ones_reg, ans_reg;
    logic [DATA_W-1:0] count_reg;

    // Memory ports.
    logic              rd_en, wr_en, hist_we, load_out;
    logic [DATA_W-1:0] cws_q, pro_q, hist_q, rr_q;
    logic [IDX_W-1:0]  rr_rd_addr;
    logic [HADDR_W-1:0] hist_rd_addr, hist_wr_addr;
    logic [DATA_W-1:0] cws_new, rr_val, ones_val;

    logic req_bad, col_ge_lim, row_gt_lim, col_le_lim, last_col, last_row;

    assign req_bad = (32'(zero_count) > MAX_COUNT) || (32'(ones_count) > MAX_COUNT)
                     || (32'(run_limit) > MAX_LIMIT);
    assign col_ge_lim = 32'(col_reg) >= 32'(lim_reg);
    assign col_le_lim = 32'(col_reg) <= 32'(lim_reg);
    assign row_gt_lim = 32'(row_reg) > 32'(lim_reg);
    assign last_col = col_reg == oc_reg;
    assign last_row = row_reg == zc_reg;

    // The ring entry that leaves the window lies run_limit columns back in this row.
    assign rr_rd_addr = col_ge_lim ? IDX_W'(32'(col_reg) - 32'(lim_reg)) : '0;
    assign hist_rd_addr = rd_base_reg + HADDR_W'(col_reg);
    assign hist_wr_addr = wr_base_reg + HADDR_W'(col_reg);

    // Column window slides down one row: add the previous row, drop the row that left.
    assign cws_new = row_gt_lim ? mod_sub(sum_reg, hist_q) : sum_reg;

    // Column zero holds the base zeros-ending count and no ones-ending strings.
    always_comb
    begin
        if (col_reg == '0)
        begin
            rr_val = (row_reg != '0 && 32'(row_reg) <= 32'(lim_reg))
                     ? DATA_W'(1) : '0;
            ones_val = '0;
        end
        else
        begin
            rr_val = cws_new;
            if (row_reg == '0)
            begin
                ones_val = col_le_lim ? DATA_W'(1) : '0;
            end
            else
            begin
                ones_val = ring_reg;
            end
        end
    end

    rlbc_ram #(.DEPTH(ROW_W)) u_cws_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (col_reg),
        .rd_data (cws_q),
        .wr_en   (wr_en),
        .wr_addr (col_reg),
        .wr_data (cws_new)
    );

    rlbc_ram #(.DEPTH(ROW_W)) u_pro_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (col_reg),
        .rd_data (pro_q),
        .wr_en   (wr_en),
        .wr_addr (col_reg),
        .wr_data (ones_val)
    );

    rlbc_ram #(.DEPTH(ROW_W)) u_ring_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rr_rd_addr),
        .rd_data (rr_q),
        .wr_en   (wr_en),
        .wr_addr (col_reg),
        .wr_data (rr_val)
    );

    rlbc_ram #(.DEPTH(HIST_D)) u_hist_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (hist_rd_addr),
        .rd_data (hist_q),
        .wr_en   (hist_we),
        .wr_addr (hist_wr_addr),
        .wr_data (ones_val)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = req_bad ? S_FINISH : S_READ;
                end
            end
            S_READ:   state_next = S_ADD;
            S_ADD:    state_next = S_UPD;
            S_UPD:    state_next = S_RING;
            S_RING:   state_next = (last_col && last_row) ? S_FINISH : S_READ;
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        in_ready = 1'b0;
        rd_en = 1'b0;
        wr_en = 1'b0;
        hist_we = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:   in_ready = 1'b1;
            S_READ:   rd_en = 1'b1;
            S_ADD:    ;
            S_UPD:
            begin
                wr_en = 1'b1;
                hist_we = !last_row;
            end
            S_RING:   ;
            S_FINISH: load_out = !out_valid_reg || out_ready;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            zc_reg <= '0;
            oc_reg <= '0;
            lim_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
            wr_base_reg <= '0;
            rd_base_reg <= '0;
            bad_reg <= 1'b0;
            bad_out_reg <= 1'b0;
            ring_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                bad_out_reg <= bad_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        zc_reg <= IDX_W'(zero_count);
                        oc_reg <= IDX_W'(ones_count);
                        lim_reg <= LIM_W'(run_limit);
                        bad_reg <= req_bad;
                        row_reg <= '0;
                        col_reg <= '0;
                        wr_base_reg <= '0;
                        rd_base_reg <= '0;
                    end
                end
                S_RING:
                begin
                    if (col_reg == '0)
                    begin
                        ring_reg <= rrv_reg;
                    end
                    else if (lim_reg != '0)
                    begin
                        ring_reg <= mod_add(r1_reg, cnew_reg);
                    end
                    if (last_col)
                    begin
                        if (!last_row)
                        begin
                            row_reg <= row_reg + 1'b1;
                            col_reg <= '0;
                            wr_base_reg <= wr_base_reg + HADDR_W'(ROW_W);
                            if (row_gt_lim)
                            begin
                                rd_base_reg <= rd_base_reg + HADDR_W'(ROW_W);
                            end
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            ans_reg <= '0;
        end
        if (state_reg == S_ADD)
        begin
            sum_reg <= (row_reg == '0) ? '0 : mod_add(cws_q, pro_q);
            // With a zero limit the entry that leaves is the one entering, so skip both.
            r1_reg <= (col_ge_lim && lim_reg != '0 && col_reg != '0)
                      ? mod_sub(ring_reg, rr_q) : ring_reg;
        end
        if (state_reg == S_UPD)
        begin
            cnew_reg <= cws_new;
            rrv_reg <= rr_val;
            ones_reg <= ones_val;
        end
        if (state_reg == S_RING && last_col)
        begin
            ans_reg <= mod_add(rrv_reg, ones_reg);
        end
        if (load_out)
        begin
            count_reg <= bad_reg ? '0 : ans_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign string_count = count_reg;
    assign bad_request = bad_out_reg;

`ifndef SYNTHESIS
    a_ring_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RING |-> ring_reg < PRIME[DATA_W-1:0])
        else $error("ring total left the residue range");

    a_window_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RING |-> cnew_reg < PRIME[DATA_W-1:0])
        else $error("column window sum left the residue range");

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> col_reg <= oc_reg && row_reg <= zc_reg)
        else $error("table walk ran past the request bounds");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_request |-> string_count == '0)
        else $error("rejected request returned a nonzero count");
`endif

endmodule

>>> rtl/rlbc_ram.sv
// Simple dual-port synchronous RAM with registered read.
module rlbc_ram
    import rlbc_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_COUNT + 1,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> bench/tb_run_limited_binary_count_core.sv
// Self-checking testbench for the run-limited binary string counter core.
`timescale 1ns / 100ps

module tb_run_limited_binary_count_core
    import rlbc_pkg::*;
();

    localparam int BOUND = DEF_MAX_COUNT;
    localparam int LIM_BOUND = DEF_MAX_LIMIT;
    localparam longint MODULUS = 1000000007;

    // One request as the sender offers it.
    typedef struct packed {
        logic [IN_W-1:0] zeros;
        logic [IN_W-1:0] ones;
        logic [IN_W-1:0] limit;
    } request_t;

    // One predicted result.
    typedef struct packed {
        logic [DATA_W-1:0] count;
        logic              bad;
    } answer_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [IN_W-1:0]   zero_count;
    logic [IN_W-1:0]   ones_count;
    logic [IN_W-1:0]   run_limit;
    logic              out_valid;
    logic              out_ready;
    logic [DATA_W-1:0] string_count;
    logic              bad_request;

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    request_t next_request;
    answer_t  got_answer;
    answer_t  want_answer;
    int       mismatch_count;

    // When set, neither side idles; used for the calm stretch of the run.
    logic     no_gaps;
    // A one-cycle pulse from the stimulus process starts a long receiver hold-off.
    logic     hold_start;
    int       hold_left;

    // Work tables of the predictor: strings ending in a zero and in a one,
    // indexed by zeros used and ones used, plus the per-column window sums.
    int unsigned zero_end[0:BOUND][0:BOUND];
    int unsigned one_end[0:BOUND][0:BOUND];
    int unsigned col_window[0:BOUND];

    run_limited_binary_count_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .zero_count   (zero_count),
        .ones_count   (ones_count),
        .run_limit    (run_limit),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .string_count (string_count),
        .bad_request  (bad_request)
    );

    always #10 clk = ~clk;

    function automatic int unsigned add_mod(int unsigned a, int unsigned b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s >= MODULUS)
        begin
            s = s - MODULUS;
        end
        return int'(s);
    endfunction

    function automatic int unsigned sub_mod(int unsigned a, int unsigned b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
        begin
            d = d + MODULUS;
        end
        return int'(d);
    endfunction

    // Counts the strings with the given digit counts and no run longer than the limit.
    // Each zeros-ending cell sums the ones-ending cells of the last 'limit' rows in its
    // column; each ones-ending cell sums the zeros-ending cells of the last 'limit'
    // columns in its row. Row zero is seeded directly.
    function answer_t count_limited_strings(request_t req);
        int          zc;
        int          oc;
        int          lim;
        int unsigned run_sum;
        int unsigned held;
        answer_t     res;
        zc = req.zeros;
        oc = req.ones;
        lim = req.limit;
        res.count = '0;
        res.bad = 1'b0;
        if (zc > BOUND || oc > BOUND || lim > LIM_BOUND)
        begin
            res.bad = 1'b1;
            return res;
        end
        for (int o = 0; o <= oc; o++)
        begin
            col_window[o] = 0;
        end
        for (int z = 0; z <= zc; z++)
        begin
            for (int o = 0; o <= oc; o++)
            begin
                if (z >= 1)
                begin
                    col_window[o] = add_mod(col_window[o], one_end[z-1][o]);
                end
                if (z >= lim + 1)
                begin
                    col_window[o] = sub_mod(col_window[o], one_end[z-1-lim][o]);
                end
            end
            zero_end[z][0] = (z >= 1 && z <= lim) ? 1 : 0;
            one_end[z][0] = 0;
            run_sum = zero_end[z][0];
            for (int o = 1; o <= oc; o++)
            begin
                zero_end[z][o] = col_window[o];
                held = run_sum;
                run_sum = add_mod(run_sum, col_window[o]);
                if (o >= lim)
                begin
                    run_sum = sub_mod(run_sum, zero_end[z][o-lim]);
                end
                if (z == 0)
                begin
                    held = (o <= lim) ? 1 : 0;
                end
                one_end[z][o] = held;
            end
        end
        res.count = DATA_W'(add_mod(zero_end[zc][oc], one_end[zc][oc]));
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic queue_request(int z, int o, int l);
        request_t r;
        r.zeros = IN_W'(z);
        r.ones = IN_W'(o);
        r.limit = IN_W'(l);
        pending_requests.push_back(r);
    endtask

    // Mostly small tables so the run stays short; a few requests with any 9-bit values,
    // most of them out of bounds, and rarely a large table.
    task automatic queue_random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            queue_request($urandom_range(0, 511), $urandom_range(0, 511),
                          $urandom_range(0, 511));
        end
        else if (pick < 8)
        begin
            queue_request($urandom_range(100, 256), $urandom_range(100, 256),
                          $urandom_range(0, 256));
        end
        else
        begin
            queue_request($urandom_range(0, 16), $urandom_range(0, 16),
                          $urandom_range(0, 18));
        end
    endtask

    // Driver: offers the pending requests, idling at random between them unless no_gaps
    // is set. The prediction is taken at the edge where the request is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            zero_count <= '0;
            ones_count <= '0;
            run_limit <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_answers.push_back(
                    count_limited_strings({zero_count, ones_count, run_limit}));
            end
            if (!in_valid || in_ready)
            begin
                if (pending_requests.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 15))
                begin
                    next_request = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    zero_count <= next_request.zeros;
                    ones_count <= next_request.ones;
                    run_limit <= next_request.limit;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver hold-off counter, kept in a process of its own.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_start && hold_left == 0)
        begin
            hold_left <= 400;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver readiness: held low during a hold-off, otherwise random, or high while no_gaps is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= no_gaps || ($urandom_range(0, 99) >= 15);
        end
    end

    // Monitor: every accepted result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_answer.count = string_count;
            got_answer.bad = bad_request;
            if (expected_answers.size() == 0)
            begin
                report_mismatch("unexpected result", got_answer.count, -1);
            end
            else
            begin
                want_answer = expected_answers.pop_front();
                if (got_answer.count !== want_answer.count)
                begin
                    report_mismatch("string_count", got_answer.count, want_answer.count);
                end
                if (got_answer.bad !== want_answer.bad)
                begin
                    report_mismatch("bad_request", got_answer.bad, want_answer.bad);
                end
            end
        end
    end

    // Waits until the sender has nothing left and every result has come back.
    // The check is made at the falling edge, when the clocked processes have settled.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_answers.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        no_gaps = 1'b0;
        hold_start = 1'b0;
        mismatch_count = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests: smallest and largest tables, empty counts,
        // a zero run limit and requests beyond the built bounds.
        queue_request(1, 1, 1);
        queue_request(0, 0, 5);
        queue_request(0, 5, 5);
        queue_request(5, 0, 5);
        queue_request(0, 5, 3);
        queue_request(5, 0, 3);
        queue_request(3, 3, 0);
        queue_request(0, 0, 0);
        queue_request(4, 4, 1);
        queue_request(10, 10, 2);
        queue_request(12, 7, 256);
        queue_request(256, 1, 256);
        queue_request(1, 256, 1);
        queue_request(256, 256, 256);
        queue_request(255, 3, 255);
        queue_request(257, 1, 1);
        queue_request(1, 257, 1);
        queue_request(1, 1, 257);
        queue_request(511, 511, 511);
        queue_request(256, 256, 0);
        queue_request(8, 8, 8);
        wait_drained();

        // The sender stays quiet until every result is in; then the receiver
        // holds off while small requests keep coming, so the core stalls its input.
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            queue_request($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 4));
        end
        wait_drained();

        for (int i = 0; i < 75; i++)
        begin
            // A calm stretch in the middle with no idling on either side.
            if (i == 40)
            begin
                while (pending_requests.size() != 0)
                begin
                    @(posedge clk);
                end
                no_gaps = 1'b1;
            end
            if (i == 60)
            begin
                while (pending_requests.size() != 0)
                begin
                    @(posedge clk);
                end
                no_gaps = 1'b0;
            end
            queue_random_request();
        end
        wait_drained();
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #200000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> run_limited_binary_count_core.f
rtl/rlbc_pkg.sv
rtl/rlbc_ram.sv
rtl/run_limited_binary_count_core.sv
bench/tb_run_limited_binary_count_core.sv
